// ----- hdl/ggns_pkg.sv -----
// ggns_pkg: shared types and constants of the greedy graph nearest search block
// no dependencies; imported by the interfaces and every module under hdl
`default_nettype none

package ggns_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DOC_W       = 16;
  localparam int unsigned LAYER_W     = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ENTRY_W     = 5;
  localparam int unsigned LAYER_COUNT = 3;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    NB_PREV = 2'd0,
    NB_NEXT = 2'd1,
    NB_DONE = 2'd2
  } nbr_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ENTRY,
    S_NBR,
    S_NWAIT,
    S_LABEL,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/ggns_if.sv -----
// ggns_if: valid/ready channel interfaces for request and result beats
// depends on ggns_pkg for the field widths
`default_nettype none

interface ggns_in_if;
  import ggns_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [DOC_W-1:0]          doc_id;
  logic signed [COORD_W-1:0] coord_0;
  logic signed [COORD_W-1:0] coord_1;
  logic signed [COORD_W-1:0] coord_2;
  logic signed [COORD_W-1:0] coord_3;
  logic [LAYER_W-1:0]        layer;

  modport source (
    output valid, action, doc_id, coord_0, coord_1, coord_2, coord_3, layer,
    input  ready
  );
  modport sink (
    input  valid, action, doc_id, coord_0, coord_1, coord_2, coord_3, layer,
    output ready
  );
endinterface

interface ggns_out_if;
  import ggns_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DOC_W-1:0]    found_id;

  modport source (
    output valid, status, found_id,
    input  ready
  );
  modport sink (
    input  valid, status, found_id,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/ggns_dist_unit.sv -----
// ggns_dist_unit: node coordinate memory and the shared squared-distance unit
// one dimension per cycle through a single registered multiplier; uses ggns_pkg
`default_nettype none

module ggns_dist_unit #(
  parameter int unsigned MAX_NODES  = 32,
  parameter int unsigned DIMENSIONS = 4,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        wr_en_i,
  input  wire logic [$clog2(MAX_NODES)-1:0]                wr_addr_i,
  input  wire logic [DIMENSIONS-1:0][COORD_BITS-1:0]       wr_data_i,
  input  wire logic                                        start_i,
  input  wire logic [$clog2(MAX_NODES)-1:0]                rd_addr_i,
  input  wire logic [DIMENSIONS-1:0][COORD_BITS-1:0]       query_i,
  output logic                                             done_o,
  output logic [2*COORD_BITS+1:0]                          dist_o
);
  import ggns_pkg::*;

  localparam int unsigned DIM_CW = $clog2(DIMENSIONS + 1);
  localparam int unsigned DIM_IW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int unsigned SQ_W   = 2 * COORD_BITS;
  localparam int unsigned MAG_W  = COORD_BITS + 1;
  localparam int unsigned DIST_W = 2 * COORD_BITS + 2;

  logic [DIMENSIONS-1:0][COORD_BITS-1:0] coord_mem [MAX_NODES];
  logic [DIMENSIONS-1:0][COORD_BITS-1:0] rd_q;

  logic              busy_q, busy_d;
  logic [DIM_CW-1:0] cnt_q, cnt_d;
  logic              mul_vld_q, mul_vld_d;
  logic [SQ_W-1:0]   sq_q;
  logic [DIST_W-1:0] acc_q;

  logic [DIM_IW-1:0]       dim_idx;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic [2*MAG_W-1:0]      prod;
  logic                    mul_go;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      coord_mem[wr_addr_i] <= wr_data_i;
    end
    if (start_i) begin
      rd_q <= coord_mem[rd_addr_i];
    end
  end

  assign dim_idx = cnt_q[DIM_IW-1:0];
  assign mul_go  = busy_q && (cnt_q < DIM_CW'(DIMENSIONS));
  assign done_o  = busy_q && (cnt_q == DIM_CW'(DIMENSIONS)) && !mul_vld_q;
  assign dist_o  = acc_q;

  always_comb begin
    diff = $signed({rd_q[dim_idx][COORD_BITS-1], rd_q[dim_idx]})
         - $signed({query_i[dim_idx][COORD_BITS-1], query_i[dim_idx]});
    mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    prod = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
  end

  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    mul_vld_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (mul_go) begin
      cnt_d     = cnt_q + DIM_CW'(1);
      mul_vld_d = 1'b1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      mul_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      mul_vld_q <= mul_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      sq_q <= prod[SQ_W-1:0];
    end
    if (start_i) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + DIST_W'(sq_q);
    end
  end

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("distance unit restarted while busy");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(DIMENSIONS+2) done_o)
    else $error("distance result not ready on time");

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q && !mul_vld_q)
    else $error("distance unit kept running after done");

endmodule

`default_nettype wire

// ----- hdl/greedy_graph_nearest_search.sv -----
// greedy_graph_nearest_search: top level with the walk sequencer and label store
// depends on ggns_pkg, ggns_if and ggns_dist_unit
//
// usage
//   item_i carries request beats (insert or search), result_o one result beat per
//   request; both are valid/ready. cfg_we_i/cfg_wdata_i write the entry node.
//   an insert appends a node at the next free slot; its neighbours are always
//   the slots just below and just above it, on every layer below LAYER_COUNT.
//   a search starts at the entry node and steps greedily to a strictly closer
//   neighbour until a full scan of the current node changes nothing.
//   one request is processed at a time; item_i.ready is high only when idle.
//   insert or empty search: the request passes S_DECODE, then S_RESP registers
//   the result. search: S_DECODE starts the entry distance and S_ENTRY waits for
//   it; each neighbour distance is started in S_NBR and awaited in S_NWAIT, and
//   each scan ends in S_NBR; then S_LABEL reads the label and S_RESP registers
//   the result; every distance goes through the single distance unit.
//   the result waits in an output register; a new request is accepted while it
//   waits, and that request's result stalls until the receiver takes the beat.
//   reset empties the store and sets the entry node to slot 0.
`default_nettype none

module greedy_graph_nearest_search #(
  parameter int unsigned MAX_NODES  = 32,
  parameter int unsigned DIMENSIONS = 4,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  ggns_in_if.sink                           item_i,
  ggns_out_if.source                        result_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [ggns_pkg::ENTRY_W-1:0] cfg_wdata_i
);
  import ggns_pkg::*;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned CMP_W  = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
  localparam int unsigned DIST_W = 2 * COORD_BITS + 2;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ENTRY_W-1:0]    entry_q;
  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [DOC_W-1:0]      out_found_q, out_found_d;

  action_e                               action_q;
  logic [DOC_W-1:0]                      doc_q;
  logic [LAYER_W-1:0]                    layer_q;
  logic [DIMENSIONS-1:0][COORD_BITS-1:0] query_q, query_d;
  logic [NODE_W-1:0]                     cur_q, cur_d;
  logic [NODE_W-1:0]                     here_q, here_d;
  logic [NODE_W-1:0]                     nb_q, nb_d;
  logic [DIST_W-1:0]                     best_q, best_d;
  nbr_e                                  sel_q, sel_d;
  logic                                  changed_q, changed_d;
  status_e                               res_status_q, res_status_d;
  logic [DOC_W-1:0]                      lbl_q;

  logic [DOC_W-1:0] label_mem [MAX_NODES];

  logic [3:0][COORD_W-1:0] in_coord;
  logic                    accept;
  logic                    full;
  logic                    entry_ok;
  logic                    layer_ok;
  logic                    next_ok;
  logic [NODE_W-1:0]       entry_idx;
  logic [NODE_W-1:0]       slot_idx;
  logic                    mem_we;
  logic                    dist_start;
  logic [NODE_W-1:0]       dist_addr;
  logic                    dist_done;
  logic [DIST_W-1:0]       dist_val;
  logic                    out_free;

  assign in_coord  = {item_i.coord_3, item_i.coord_2, item_i.coord_1, item_i.coord_0};
  assign accept    = item_i.valid && item_i.ready;
  assign full      = (count_q == CNT_W'(MAX_NODES));
  assign entry_ok  = (count_q != '0) && (CMP_W'(entry_q) < CMP_W'(count_q));
  assign entry_idx = NODE_W'(entry_q);
  assign slot_idx  = count_q[NODE_W-1:0];
  assign layer_ok  = (int'(layer_q) < LAYER_COUNT);
  assign next_ok   = ((CNT_W'(here_q) + CNT_W'(1)) < count_q);
  assign out_free  = !out_valid_q || result_o.ready;

  assign item_i.ready      = (state_q == S_IDLE);
  assign result_o.valid    = out_valid_q;
  assign result_o.status   = out_status_q;
  assign result_o.found_id = out_found_q;

  always_comb begin
    query_d = query_q;
    for (int d = 0; d < DIMENSIONS; d++) begin
      query_d[d] = in_coord[d][COORD_BITS-1:0];
    end
  end

  ggns_dist_unit #(
    .MAX_NODES  (MAX_NODES),
    .DIMENSIONS (DIMENSIONS),
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (slot_idx),
    .wr_data_i (query_q),
    .start_i   (dist_start),
    .rd_addr_i (dist_addr),
    .query_i   (query_q),
    .done_o    (dist_done),
    .dist_o    (dist_val)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (item_i.valid) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (action_q == ACT_INSERT || !entry_ok) state_d = S_RESP;
        else                                     state_d = S_ENTRY;
      end
      S_ENTRY: begin
        if (dist_done) state_d = layer_ok ? S_NBR : S_LABEL;
      end
      S_NBR: begin
        unique case (sel_q)
          NB_PREV: if (here_q != '0) state_d = S_NWAIT;
          NB_NEXT: if (next_ok)      state_d = S_NWAIT;
          default: if (!changed_q)   state_d = S_LABEL;
        endcase
      end
      S_NWAIT: begin
        if (dist_done) state_d = S_NBR;
      end
      S_LABEL: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and strobes
  always_comb begin
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    cur_d        = cur_q;
    here_d       = here_q;
    nb_d         = nb_q;
    best_d       = best_q;
    sel_d        = sel_q;
    changed_d    = changed_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    dist_start   = 1'b0;
    dist_addr    = cur_q;

    if (out_valid_q && result_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_DECODE: begin
        if (action_q == ACT_INSERT) begin
          if (full) begin
            res_status_d = ST_FULL;
          end else begin
            mem_we       = 1'b1;
            count_d      = count_q + CNT_W'(1);
            res_status_d = ST_INSERTED;
          end
        end else if (!entry_ok) begin
          res_status_d = ST_EMPTY;
        end else begin
          dist_start = 1'b1;
          dist_addr  = entry_idx;
          cur_d      = entry_idx;
        end
      end
      S_ENTRY: begin
        if (dist_done) begin
          best_d    = dist_val;
          here_d    = cur_q;
          sel_d     = NB_PREV;
          changed_d = 1'b0;
        end
      end
      S_NBR: begin
        unique case (sel_q)
          NB_PREV: begin
            if (here_q != '0) begin
              dist_start = 1'b1;
              dist_addr  = here_q - NODE_W'(1);
              nb_d       = here_q - NODE_W'(1);
            end else begin
              sel_d = NB_NEXT;
            end
          end
          NB_NEXT: begin
            if (next_ok) begin
              dist_start = 1'b1;
              dist_addr  = here_q + NODE_W'(1);
              nb_d       = here_q + NODE_W'(1);
            end else begin
              sel_d = NB_DONE;
            end
          end
          default: begin
            if (changed_q) begin
              here_d    = cur_q;
              sel_d     = NB_PREV;
              changed_d = 1'b0;
            end
          end
        endcase
      end
      S_NWAIT: begin
        if (dist_done) begin
          if (dist_val < best_q) begin
            best_d    = dist_val;
            cur_d     = nb_q;
            changed_d = 1'b1;
          end
          sel_d = (sel_q == NB_PREV) ? NB_NEXT : NB_DONE;
        end
      end
      S_LABEL: res_status_d = ST_FOUND;
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = (res_status_q == ST_FOUND) ? lbl_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      entry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) entry_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_e'(item_i.action);
      doc_q    <= item_i.doc_id;
      layer_q  <= item_i.layer;
      query_q  <= query_d;
    end
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    cur_q        <= cur_d;
    here_q       <= here_d;
    nb_q         <= nb_d;
    best_q       <= best_d;
    sel_q        <= sel_d;
    changed_q    <= changed_d;
    res_status_q <= res_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      label_mem[slot_idx] <= doc_q;
    end
    if (state_q == S_LABEL) begin
      lbl_q <= label_mem[cur_q];
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_NODES))
    else $error("stored count beyond capacity");

  a_walk_in_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NBR || state_q == S_NWAIT || state_q == S_LABEL)
      |-> (CNT_W'(cur_q) < count_q) && (CNT_W'(here_q) < count_q))
    else $error("walk left the stored nodes");

  a_best_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NWAIT && dist_done) |=> best_q <= $past(best_q))
    else $error("best distance grew during the walk");

  a_found_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_FOUND) |-> out_found_q == '0)
    else $error("label reported without a found status");

endmodule

`default_nettype wire

// ----- verif/greedy_graph_nearest_search_test.sv -----
// greedy_graph_nearest_search_test: self-checking bench for the greedy graph nearest search
// drives insert and search beats, predicts every result beat and compares it field by field
// depends on ggns_pkg, ggns_if and the greedy_graph_nearest_search rtl
`timescale 1ns / 1ps

module greedy_graph_nearest_search_test;
  import ggns_pkg::*;

  localparam int unsigned NODE_SLOTS  = 32;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned RAND_ITEMS  = 500;

  typedef logic [3:0][COORD_W-1:0] point_t;

  typedef struct packed {
    action_e            act;
    logic [DOC_W-1:0]   doc;
    point_t             pos;
    logic [LAYER_W-1:0] lyr;
  } request_t;

  typedef struct packed {
    status_e          status;
    logic [DOC_W-1:0] found_id;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [ENTRY_W-1:0]  cfg_wdata;

  ggns_in_if  req_bus ();
  ggns_out_if ans_bus ();

  greedy_graph_nearest_search u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (req_bus),
    .result_o    (ans_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // graph mirror
  logic [DOC_W-1:0]    node_doc [NODE_SLOTS];
  point_t              node_pos [NODE_SLOTS];
  int unsigned         node_total = 0;
  int unsigned         entry_slot = 0;

  request_t            request_backlog [$];
  outcome_t            pending_answers [$];
  point_t              planned_pos [$];
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         fail_count     = 0;
  int unsigned         cycle_count    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned sq_span(point_t a, point_t b);
    longint unsigned total;
    longint          diff;
    total = 0;
    for (int d = 0; d < 4; d++) begin
      diff = longint'($signed(a[d])) - longint'($signed(b[d]));
      if (diff < 0) diff = -diff;
      total += longint'(diff) * longint'(diff);
    end
    return total;
  endfunction

  // neighbours of slot n are n-1 then n+1 on every real layer
  function automatic outcome_t greedy_outcome(request_t r);
    outcome_t        res;
    int unsigned     cur;
    int unsigned     here;
    int unsigned     nb;
    longint unsigned best;
    longint unsigned span;
    bit              moved;
    res.status   = ST_FOUND;
    res.found_id = '0;
    if (r.act == ACT_INSERT) begin
      if (node_total == NODE_SLOTS) begin
        res.status = ST_FULL;
      end else begin
        node_doc[node_total] = r.doc;
        node_pos[node_total] = r.pos;
        node_total++;
        res.status = ST_INSERTED;
      end
      return res;
    end
    if (node_total == 0 || entry_slot >= node_total) begin
      res.status = ST_EMPTY;
      return res;
    end
    cur  = entry_slot;
    best = sq_span(node_pos[cur], r.pos);
    if (r.lyr < LAYER_COUNT) begin
      moved = 1'b1;
      while (moved) begin
        moved = 1'b0;
        here  = cur;
        for (int k = 0; k < 2; k++) begin
          nb = (k == 0) ? here - 1 : here + 1;
          if (nb < node_total) begin
            span = sq_span(node_pos[nb], r.pos);
            if (span < best) begin
              best  = span;
              cur   = nb;
              moved = 1'b1;
            end
          end
        end
      end
    end
    res.found_id = node_doc[cur];
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    request_t nxt;
    request_t seen;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        seen.act = action_e'(req_bus.action);
        seen.doc = req_bus.doc_id;
        seen.pos = {req_bus.coord_3, req_bus.coord_2, req_bus.coord_1, req_bus.coord_0};
        seen.lyr = req_bus.layer;
        pending_answers.push_back(greedy_outcome(seen));
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_backlog.pop_front();
          req_bus.valid   <= 1'b1;
          req_bus.action  <= nxt.act;
          req_bus.doc_id  <= nxt.doc;
          req_bus.coord_0 <= nxt.pos[0];
          req_bus.coord_1 <= nxt.pos[1];
          req_bus.coord_2 <= nxt.pos[2];
          req_bus.coord_3 <= nxt.pos[3];
          req_bus.layer   <= nxt.lyr;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    outcome_t want;
    if (!rst_ni) begin
      ans_bus.ready <= 1'b0;
    end else begin
      if (ans_bus.valid && ans_bus.ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result beat status %0d found_id %h",
                   $time, ans_bus.status, ans_bus.found_id);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          if (ans_bus.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, ans_bus.status);
            fail_count++;
          end
          if (ans_bus.found_id !== want.found_id) begin
            $display("%0t: found_id expected %h actual %h", $time, want.found_id,
                     ans_bus.found_id);
            fail_count++;
          end
        end
      end
      ans_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_request(action_e act, logic [DOC_W-1:0] doc, point_t pos,
                              logic [LAYER_W-1:0] lyr);
    request_t r;
    r.act = act;
    r.doc = doc;
    r.pos = pos;
    r.lyr = lyr;
    request_backlog.push_back(r);
  endtask

  task automatic drain;
    while (request_backlog.size() != 0 || pending_answers.size() != 0 || req_bus.valid)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_entry(logic [ENTRY_W-1:0] slot);
    @(posedge clk_i);
    cfg_we     <= 1'b1;
    cfg_wdata  <= slot;
    entry_slot = slot;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic point_t spread_point();
    point_t p;
    for (int d = 0; d < 4; d++) begin
      if ($urandom_range(3) == 0) p[d] = COORD_W'($urandom);
      else p[d] = COORD_W'($urandom_range(1023)) - COORD_W'(512);
    end
    return p;
  endfunction

  task automatic push_random(int unsigned insert_pct);
    request_t r;
    point_t   base;
    r.doc = DOC_W'($urandom);
    r.lyr = LAYER_W'($urandom_range(3));
    r.act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_SEARCH;
    if (r.act == ACT_INSERT || planned_pos.size() == 0 || $urandom_range(1) == 0) begin
      r.pos = spread_point();
    end else begin
      base = planned_pos[$urandom_range(planned_pos.size() - 1)];
      for (int d = 0; d < 4; d++)
        r.pos[d] = base[d] + COORD_W'($urandom_range(64)) - COORD_W'(32);
    end
    if (r.act == ACT_INSERT) planned_pos.push_back(r.pos);
    request_backlog.push_back(r);
  endtask

  initial begin
    int unsigned send_mode [4];
    int unsigned stall_mode [4];
    int unsigned entry_mode [4];
    int unsigned insert_mode [4];
    send_mode   = '{0, 60, 0, 22};
    stall_mode  = '{0, 0, 60, 22};
    entry_mode  = '{5, 31, $urandom_range(31), 0};
    insert_mode = '{30, 10, 10, 10};

    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_bus.valid   = 1'b0;
    req_bus.action  = ACT_INSERT;
    req_bus.doc_id  = '0;
    req_bus.coord_0 = '0;
    req_bus.coord_1 = '0;
    req_bus.coord_2 = '0;
    req_bus.coord_3 = '0;
    req_bus.layer   = '0;
    ans_bus.ready   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // search on an empty store, extreme labels and coordinates
    push_request(ACT_SEARCH, 16'h1234, '0, 2'd0);
    push_request(ACT_INSERT, 16'h0000, {4{16'h8000}}, 2'd3);
    push_request(ACT_INSERT, 16'hffff, {4{16'h7fff}}, 2'd1);
    push_request(ACT_INSERT, 16'h0001, '0, 2'd2);
    push_request(ACT_SEARCH, 16'hffff, {4{16'h7fff}}, 2'd0);
    push_request(ACT_SEARCH, 16'h0000, {4{16'h7fff}}, 2'd3);
    push_request(ACT_SEARCH, 16'h0000, '0, 2'd1);
    push_request(ACT_SEARCH, 16'h0000, '0, 2'd2);
    // equal distances: slot 3 is as far from the query as slot 2
    push_request(ACT_INSERT, 16'h0003, {16'd2, 48'd0}, 2'd0);
    push_request(ACT_SEARCH, 16'h0000, {16'd1, 48'd0}, 2'd0);
    drain();

    // entry node not stored, and a walk from the top slot
    write_entry(5'd31);
    push_request(ACT_SEARCH, 16'h0000, '0, 2'd0);
    drain();
    write_entry(5'd3);
    push_request(ACT_SEARCH, 16'h0000, {4{16'h8000}}, 2'd0);
    drain();
    write_entry(5'd4);
    push_request(ACT_SEARCH, 16'h0000, '0, 2'd1);
    drain();
    planned_pos.push_back({4{16'h8000}});
    planned_pos.push_back({4{16'h7fff}});
    planned_pos.push_back('0);
    planned_pos.push_back({16'd2, 48'd0});

    for (int ph = 0; ph < 4; ph++) begin
      write_entry(ENTRY_W'(entry_mode[ph]));
      send_idle_pct  = send_mode[ph];
      recv_stall_pct = stall_mode[ph];
      for (int n = 0; n < RAND_ITEMS; n++) push_random(insert_mode[ph]);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- greedy_graph_nearest_search.f -----
hdl/ggns_pkg.sv
hdl/ggns_if.sv
hdl/ggns_dist_unit.sv
hdl/greedy_graph_nearest_search.sv
verif/greedy_graph_nearest_search_test.sv
